>>> rtl/core/fsoc_pkg.sv
// Shared types and constants of the formation slot offset calculator.
package fsoc_pkg;

	// field widths
	localparam int SLOT_W = 8;
	localparam int POS_W  = 25;
	localparam int HDG_W  = 9;
	localparam int TURN_W = 16;
	localparam int GAP_W  = 16;
	localparam int RAD_W  = 22;
	localparam int ADDR_W = 2;

	// pattern codes
	localparam logic [2:0] PAT_NONE   = 3'd0;
	localparam logic [2:0] PAT_LINE   = 3'd1;
	localparam logic [2:0] PAT_WEDGE  = 3'd2;
	localparam logic [2:0] PAT_CIRCLE = 3'd3;
	localparam logic [2:0] PAT_COLUMN = 3'd4;

	// register indexes
	localparam logic [ADDR_W-1:0] REG_PATTERN = 2'd0;
	localparam logic [ADDR_W-1:0] REG_MEMBERS = 2'd1;
	localparam logic [ADDR_W-1:0] REG_GAP     = 2'd2;
	localparam logic [GAP_W-1:0]  GAP_RESET   = 16'd1000;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// divider and trig pipeline depths
	localparam int MOD_STEPS  = 8;
	localparam int TURN_STEPS = 16;
	localparam int DIV_STEPS  = 17;
	localparam int DIV_LAT    = MOD_STEPS + DIV_STEPS;
	localparam int TRIG_LAT   = 12;
	localparam int PIPE_LAT   = DIV_LAT + TRIG_LAT;

	localparam logic [8:0] DEG_FULL = 9'd360;

	// Q30 work format
	localparam int          WORK_BITS = 30;
	localparam logic [30:0] WORK_ONE  = 31'h4000_0000;
	localparam logic [31:0] PI_WORK   = 32'd3373259426;

	// exact division of a 30-bit value by a small constant: (w * MAG) >> SH
	localparam logic [31:0] SIN_MAG [4] = '{
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 33) + 64'd5) / 64'd6)
	};
	localparam int SIN_SH [4] = '{37, 36, 35, 33};
	localparam logic [31:0] COS_MAG [4] = '{
		32'(((64'd1 << 37) + 64'd89) / 64'd90),
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 34) + 64'd11) / 64'd12)
	};
	localparam int COS_SH [4] = '{37, 36, 35, 34};

	// radius: 24-bit n*gap divided by 6
	localparam logic [24:0] RAD_MAG = 25'(((64'd1 << 27) + 64'd5) / 64'd6);
	localparam int          RAD_SH  = 27;

	typedef struct packed {
		logic                    circ;
		logic [SLOT_W-1:0]       ring_idx;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} fsoc_item_t;

endpackage

>>> rtl/core/fsoc_front.sv
// Front stage: takes a slot beat, works out the straight patterns, flags circle slots.
module fsoc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fsoc_pkg::SLOT_W-1:0] slot,
	input  logic [2:0]                  kind,
	input  logic [7:0]                  members,
	input  logic [fsoc_pkg::GAP_W-1:0]  gap,
	input  logic                        q_full,
	output logic                        push,
	output fsoc_pkg::fsoc_item_t        item
);
	import fsoc_pkg::*;

	logic                    f_valid_s1;
	fsoc_item_t              item_s1;
	fsoc_item_t              item_c;
	logic [SLOT_W-1:0]       row;
	logic [23:0]             prod;
	logic signed [POS_W-1:0] prod_sv;
	logic signed [POS_W-1:0] half_sv;
	logic signed [POS_W-1:0] hgap_sv;

	assign in_ready = !f_valid_s1 || !q_full;
	assign push     = f_valid_s1 && !q_full;
	assign item     = item_s1;

	always_comb begin
		case (kind)
			PAT_LINE:   row = slot;
			PAT_WEDGE:  row = SLOT_W'((9'(slot) + 9'd1) >> 1);
			PAT_COLUMN: row = slot >> 1;
			default:    row = '0;
		endcase
		prod    = 24'(row) * 24'(gap);
		prod_sv = $signed({1'b0, prod});
		half_sv = $signed({2'b00, prod[23:1]});
		hgap_sv = $signed({10'd0, gap[GAP_W-1:1]});

		item_c.circ     = (kind == PAT_CIRCLE) && (members >= 8'd2) && (slot != '0);
		item_c.ring_idx = slot - 8'd1;
		item_c.x        = '0;
		item_c.y        = '0;
		case (kind)
			PAT_LINE: begin
				item_c.y = -prod_sv;
			end
			PAT_WEDGE: begin
				// slot 0 has row 0, so it lands on the origin by itself
				item_c.y = -prod_sv;
				item_c.x = slot[0] ? -half_sv : half_sv;
			end
			PAT_COLUMN: begin
				item_c.y = -prod_sv;
				item_c.x = slot[0] ? hgap_sv : -hgap_sv;
			end
			default: begin
				item_c.x = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			f_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

>>> rtl/core/fsoc_queue.sv
// Short FIFO between the front stage and the back pipeline.
module fsoc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fsoc_pkg::fsoc_item_t wr_item,
	input  logic                 pop,
	output fsoc_pkg::fsoc_item_t rd_item,
	output logic                 full,
	output logic                 empty
);
	import fsoc_pkg::*;

	fsoc_item_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCNT_W'(QUEUE_DEPTH)))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule

>>> rtl/core/fsoc_div.sv
// Pipelined ring divider: index mod n, then turn fraction and heading, one bit per stage.
module fsoc_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [7:0]                  ring_n,
	input  logic [fsoc_pkg::SLOT_W-1:0] ring_idx,
	output logic [fsoc_pkg::TURN_W-1:0] turn,
	output logic [fsoc_pkg::HDG_W-1:0]  heading
);
	import fsoc_pkg::*;

	logic [7:0]        mr_s [MOD_STEPS];
	logic [7:0]        ma_s [MOD_STEPS-1];
	logic [7:0]        tr_s [TURN_STEPS-1];
	logic [TURN_W-1:0] tq_s [DIV_STEPS];
	logic [7:0]        hr_s [DIV_STEPS-1];
	logic [16:0]       hn_s [DIV_STEPS-1];
	logic [HDG_W-1:0]  hq_s [DIV_STEPS];

	// remainder of (slot - 1) by n, restoring, MSB first
	for (genvar m = 0; m < MOD_STEPS; m++) begin : g_mod
		logic [7:0] r_in;
		logic [7:0] a_in;
		logic [8:0] trial;
		if (m == 0) begin : g_head
			assign r_in = '0;
			assign a_in = ring_idx;
		end else begin : g_body
			assign r_in = mr_s[m-1];
			assign a_in = ma_s[m-1];
		end
		assign trial = {r_in, a_in[MOD_STEPS-1-m]};
		always_ff @(posedge clk) begin
			if (en) begin
				mr_s[m] <= (trial >= {1'b0, ring_n}) ? 8'(trial - {1'b0, ring_n}) : trial[7:0];
			end
		end
		if (m < MOD_STEPS-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					ma_s[m] <= a_in;
				end
			end
		end
	end

	// turn = k*2^16/n (fraction bits) and heading = k*360/n, side by side
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_frac
		logic [7:0]        tr_in;
		logic [TURN_W-1:0] tq_in;
		logic [7:0]        hr_in;
		logic [16:0]       hn_in;
		logic [HDG_W-1:0]  hq_in;
		logic [8:0]        h_trial;
		logic              h_ge;
		if (j == 0) begin : g_head
			assign tr_in = mr_s[MOD_STEPS-1];
			assign tq_in = '0;
			assign hr_in = '0;
			assign hn_in = 17'(mr_s[MOD_STEPS-1]) * 17'(DEG_FULL);
			assign hq_in = '0;
		end else begin : g_body
			if (j < TURN_STEPS) begin : g_tr
				assign tr_in = tr_s[j-1];
			end else begin : g_tr_done
				assign tr_in = '0;
			end
			assign tq_in = tq_s[j-1];
			assign hr_in = hr_s[j-1];
			assign hn_in = hn_s[j-1];
			assign hq_in = hq_s[j-1];
		end

		assign h_trial = {hr_in, hn_in[DIV_STEPS-1-j]};
		assign h_ge    = (h_trial >= {1'b0, ring_n});

		if (j < TURN_STEPS) begin : g_turn
			logic [8:0] t_trial;
			logic       t_ge;
			assign t_trial = {tr_in, 1'b0};
			assign t_ge    = (t_trial >= {1'b0, ring_n});
			always_ff @(posedge clk) begin
				if (en) begin
					tq_s[j] <= {tq_in[TURN_W-2:0], t_ge};
				end
			end
			if (j < TURN_STEPS-1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						tr_s[j] <= t_ge ? 8'(t_trial - {1'b0, ring_n}) : t_trial[7:0];
					end
				end
			end
		end else begin : g_turn_hold
			always_ff @(posedge clk) begin
				if (en) begin
					tq_s[j] <= tq_in;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hq_s[j] <= {hq_in[HDG_W-2:0], h_ge};
			end
		end
		if (j < DIV_STEPS-1) begin : g_hrem
			always_ff @(posedge clk) begin
				if (en) begin
					hr_s[j] <= h_ge ? 8'(h_trial - {1'b0, ring_n}) : h_trial[7:0];
					hn_s[j] <= hn_in;
				end
			end
		end
	end

	assign turn    = tq_s[DIV_STEPS-1];
	assign heading = hq_s[DIV_STEPS-1];

endmodule

>>> rtl/core/fsoc_trig.sv
// Sine/cosine of a turn fraction by fixed-point series, scaled by the ring radius.
module fsoc_trig #(
	parameter int TRIG_FRACTION_BITS = 16
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [fsoc_pkg::TURN_W-1:0]        turn,
	input  logic [7:0]                         members,
	input  logic [fsoc_pkg::GAP_W-1:0]         gap,
	output logic signed [fsoc_pkg::POS_W-1:0]  x_out,
	output logic signed [fsoc_pkg::POS_W-1:0]  y_out
);
	import fsoc_pkg::*;

	localparam int MAG_W = TRIG_FRACTION_BITS + 1;
	localparam int RSH   = WORK_BITS - TRIG_FRACTION_BITS;
	localparam logic [31:0] HALF = 32'd1 << (RSH - 1);
	localparam int PRD_W = RAD_W + MAG_W;

	typedef struct packed {
		logic [29:0] x;
		logic [29:0] x2;
		logic [1:0]  quad;
		logic        refl;
	} trig_meta_t;

	// radius from the config registers, registered through ng_q, rm_q and rad_q
	logic [7:0]       ring_n;
	logic [23:0]      ng_q;
	logic [RAD_W-1:0] rm_q;
	logic [RAD_W-1:0] rad_q;

	assign ring_n = members - 8'd1;

	always_ff @(posedge clk) begin
		ng_q  <= 24'(ring_n) * 24'(gap);
		rm_q  <= RAD_W'((49'(ng_q) * 49'(RAD_MAG)) >> RAD_SH);
		rad_q <= (rm_q < RAD_W'(gap)) ? RAD_W'(gap) : rm_q;
	end

	// stage 1: octant reduction and angle to radians
	logic [1:0]  quad_c;
	logic [13:0] u_c;
	logic        refl_c;
	logic [13:0] v_c;
	trig_meta_t  m1_s1;
	trig_meta_t  m2_s2;

	assign quad_c = turn[15:14];
	assign u_c    = turn[13:0];
	assign refl_c = (u_c > 14'h2000);
	assign v_c    = refl_c ? 14'(15'h4000 - 15'(u_c)) : u_c;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1.x    <= 30'((46'(v_c) * 46'(PI_WORK)) >> (TURN_W - 1));
			m1_s1.x2   <= '0;
			m1_s1.quad <= quad_c;
			m1_s1.refl <= refl_c;
		end
	end

	// stage 2: x squared
	always_ff @(posedge clk) begin
		if (en) begin
			m2_s2.x    <= m1_s1.x;
			m2_s2.x2   <= 30'((60'(m1_s1.x) * 60'(m1_s1.x)) >> WORK_BITS);
			m2_s2.quad <= m1_s1.quad;
			m2_s2.refl <= m1_s1.refl;
		end
	end

	// stages 3..10: nested series, a divide step then a multiply step per term
	trig_meta_t  md_s [8];
	logic [29:0] sw_s [1:3];
	logic [29:0] cw_s [1:3];
	logic [30:0] st_s [4];
	logic [30:0] ct_s [4];
	logic [30:0] s_fin_s;
	logic [30:0] c_fin_s;

	for (genvar j = 0; j < 4; j++) begin : g_term
		trig_meta_t  d_meta;
		logic [29:0] d_sw;
		logic [29:0] d_cw;
		if (j == 0) begin : g_head
			assign d_meta = m2_s2;
			assign d_sw   = m2_s2.x2;
			assign d_cw   = m2_s2.x2;
		end else begin : g_body
			assign d_meta = md_s[2*j-1];
			assign d_sw   = sw_s[j];
			assign d_cw   = cw_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[j]   <= WORK_ONE - 31'((62'(d_sw) * 62'(SIN_MAG[j])) >> SIN_SH[j]);
				ct_s[j]   <= WORK_ONE - 31'((62'(d_cw) * 62'(COS_MAG[j])) >> COS_SH[j]);
				md_s[2*j] <= d_meta;
			end
		end

		if (j < 3) begin : g_mul
			always_ff @(posedge clk) begin
				if (en) begin
					sw_s[j+1]   <= 30'((61'(md_s[2*j].x2) * 61'(st_s[j])) >> WORK_BITS);
					cw_s[j+1]   <= 30'((61'(md_s[2*j].x2) * 61'(ct_s[j])) >> WORK_BITS);
					md_s[2*j+1] <= md_s[2*j];
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en) begin
					s_fin_s     <= 31'((61'(md_s[2*j].x) * 61'(st_s[j])) >> WORK_BITS);
					c_fin_s     <= WORK_ONE -
						31'((61'(md_s[2*j].x2) * 61'(ct_s[j])) >> (WORK_BITS + 1));
					md_s[2*j+1] <= md_s[2*j];
				end
			end
		end
	end

	// stage 11: round to output precision, fold octant and quadrant
	logic [MAG_W-1:0] sr_c;
	logic [MAG_W-1:0] cr_c;
	logic [MAG_W-1:0] os_c;
	logic [MAG_W-1:0] oc_c;
	logic [MAG_W-1:0] sin_mag_s11;
	logic [MAG_W-1:0] cos_mag_s11;
	logic             sin_neg_s11;
	logic             cos_neg_s11;

	assign sr_c = MAG_W'((32'(s_fin_s) + HALF) >> RSH);
	assign cr_c = MAG_W'((32'(c_fin_s) + HALF) >> RSH);
	assign os_c = md_s[7].refl ? cr_c : sr_c;
	assign oc_c = md_s[7].refl ? sr_c : cr_c;

	always_ff @(posedge clk) begin
		if (en) begin
			case (md_s[7].quad)
				2'd0: begin
					sin_mag_s11 <= os_c; sin_neg_s11 <= 1'b0;
					cos_mag_s11 <= oc_c; cos_neg_s11 <= 1'b0;
				end
				2'd1: begin
					sin_mag_s11 <= oc_c; sin_neg_s11 <= 1'b0;
					cos_mag_s11 <= os_c; cos_neg_s11 <= 1'b1;
				end
				2'd2: begin
					sin_mag_s11 <= os_c; sin_neg_s11 <= 1'b1;
					cos_mag_s11 <= oc_c; cos_neg_s11 <= 1'b1;
				end
				default: begin
					sin_mag_s11 <= oc_c; sin_neg_s11 <= 1'b1;
					cos_mag_s11 <= os_c; cos_neg_s11 <= 1'b0;
				end
			endcase
		end
	end

	// stage 12: scale by radius, truncate toward zero, apply sign
	logic signed [POS_W-1:0] px_c;
	logic signed [POS_W-1:0] py_c;

	assign px_c = $signed(POS_W'((PRD_W'(rad_q) * PRD_W'(sin_mag_s11)) >> TRIG_FRACTION_BITS));
	assign py_c = $signed(POS_W'((PRD_W'(rad_q) * PRD_W'(cos_mag_s11)) >> TRIG_FRACTION_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= sin_neg_s11 ? -px_c : px_c;
			y_out <= cos_neg_s11 ? -py_c : py_c;
		end
	end

endmodule

>>> rtl/core/fsoc_back.sv
// Back pipeline: pops queued items, runs divider and trig, holds the result beat.
module fsoc_back #(
	parameter int TRIG_FRACTION_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  fsoc_pkg::fsoc_item_t       q_item,
	output logic                       pop,
	input  logic [7:0]                 members,
	input  logic [fsoc_pkg::GAP_W-1:0] gap,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [63:0]                out_data
);
	import fsoc_pkg::*;

	logic                    adv;
	logic                    v_s [PIPE_LAT];
	fsoc_item_t              sb_s [PIPE_LAT];
	logic [HDG_W-1:0]        hd_s [TRIG_LAT];
	logic [TURN_W-1:0]       div_turn;
	logic [HDG_W-1:0]        div_hdg;
	logic signed [POS_W-1:0] trig_x;
	logic signed [POS_W-1:0] trig_y;
	logic                    out_valid_q;
	logic signed [POS_W-1:0] out_x_q;
	logic signed [POS_W-1:0] out_y_q;
	logic [HDG_W-1:0]        out_hdg_q;

	// whole pipeline moves together whenever the output slot is free
	assign adv       = !out_valid_q || out_ready;
	assign pop       = adv && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = {5'd0, out_hdg_q, out_y_q, out_x_q};

	fsoc_div u_div (
		.clk      (clk),
		.en       (adv),
		.ring_n   (members - 8'd1),
		.ring_idx (q_item.ring_idx),
		.turn     (div_turn),
		.heading  (div_hdg)
	);

	fsoc_trig #(
		.TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
	) u_trig (
		.clk     (clk),
		.en      (adv),
		.turn    (div_turn),
		.members (members),
		.gap     (gap),
		.x_out   (trig_x),
		.y_out   (trig_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				v_s[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= pop;
			for (int i = 1; i < PIPE_LAT; i++) begin
				v_s[i] <= v_s[i-1];
			end
			out_valid_q <= v_s[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s[0] <= q_item;
			for (int i = 1; i < PIPE_LAT; i++) begin
				sb_s[i] <= sb_s[i-1];
			end
			hd_s[0] <= div_hdg;
			for (int i = 1; i < TRIG_LAT; i++) begin
				hd_s[i] <= hd_s[i-1];
			end
			if (sb_s[PIPE_LAT-1].circ) begin
				out_x_q   <= trig_x;
				out_y_q   <= trig_y;
				out_hdg_q <= hd_s[TRIG_LAT-1];
			end else begin
				out_x_q   <= sb_s[PIPE_LAT-1].x;
				out_y_q   <= sb_s[PIPE_LAT-1].y;
				out_hdg_q <= '0;
			end
		end
	end

endmodule

>>> rtl/core/formation_slot_offset_calculator.sv
// Top level of the formation slot offset calculator.
//
//  channel   | dir | beat contents (low bits first)
//  ----------+-----+-------------------------------------------------------------
//  s_axis    | in  | tdata[7:0] slot_index
//  m_axis    | out | tdata[24:0] offset_x_mm, [49:25] offset_y_mm,
//            |     | [58:50] heading_offset_deg, rest zero
//  cfg       | in  | cfg_addr 0 pattern_kind, 1 member_total, 2 gap_mm; write on cfg_we
//
//  One slot beat per cycle sustained while m_axis_tready does not stall the back end;
//  a taken beat passes the queue write, the back end (8-step modulo, 17-step ring
//  divider, 12-stage sine/cosine/scale pipeline) and the output register.
//  The front stage and a 4-beat queue keep taking slots while the back end is
//  stalled by m_axis_tready; the back end moves as one on a free output slot.
//  arst_n clears control state only; config resets to none, 0 members, 1000 mm.
//  The ring radius is registered in fsoc_trig and follows a config write.
module formation_slot_offset_calculator #(
	parameter int TRIG_FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // [7:0] slot_index
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [63:0]                  m_axis_tdata,   // x[24:0], y[49:25], hdg[58:50]
	input  logic                         cfg_we,
	input  logic [fsoc_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [15:0]                  cfg_data
);
	import fsoc_pkg::*;

	logic [2:0]       pattern_kind_q;
	logic [7:0]       member_total_q;
	logic [GAP_W-1:0] gap_mm_q;

	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	fsoc_item_t front_item;
	fsoc_item_t queue_item;

	// config registers; index 3 is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_kind_q <= PAT_NONE;
			member_total_q <= '0;
			gap_mm_q       <= GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PATTERN: pattern_kind_q <= cfg_data[2:0];
				REG_MEMBERS: member_total_q <= cfg_data[7:0];
				REG_GAP:     gap_mm_q       <= cfg_data;
				default:     gap_mm_q       <= gap_mm_q;
			endcase
		end
	end

	// front: classify the slot, straight patterns done here
	fsoc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.slot     (s_axis_tdata),
		.kind     (pattern_kind_q),
		.members  (member_total_q),
		.gap      (gap_mm_q),
		.q_full   (q_full),
		.push     (push),
		.item     (front_item)
	);

	fsoc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (pop),
		.rd_item (queue_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	// back: ring math for circle slots, output beat register
	fsoc_back #(
		.TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (queue_item),
		.pop       (pop),
		.members   (member_total_q),
		.gap       (gap_mm_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

>>> test/tb_formation_slot_offset_calculator.sv
// Testbench for the formation slot offset calculator: directed table plus random slot queries.
`timescale 1ns / 1ps

module tb_formation_slot_offset_calculator;
	import fsoc_pkg::*;

	localparam int  CYCLE_LIMIT = 400000;
	localparam int  DRAIN_WAIT  = 60;   // past the pipe latency
	localparam int  IDLE_PCT    = 23;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	typedef struct {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [HDG_W-1:0] hdg;
	} offset_t;

	// one directed row: config, slot, and a typed-in answer where obvious
	typedef struct {
		logic [2:0]  pat;
		logic [7:0]  members;
		logic [15:0] gap;
		logic [7:0]  slot;
		bit          known;
		int          x;
		int          y;
		int          hdg;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [15:0] cfg_data = '0;

	// shadow of the config registers
	logic [2:0]  cur_pat = PAT_NONE;
	logic [7:0]  cur_members = '0;
	logic [15:0] cur_gap = GAP_RESET;

	offset_t pending_offsets[$];
	int      errors = 0;
	int      cycles = 0;
	bit      no_idle = 1'b0;

	formation_slot_offset_calculator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- slot offset predictor ----------------

	function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	// sin/cos in Q30 of v/2^16 turn, v in [0, 2^13]
	function automatic void octant_sincos(input longint unsigned v,
			output longint unsigned s, output longint unsigned c);
		longint unsigned ang, a2, t;
		ang = (v * PI_Q30) >> 15;
		a2  = q30_mul(ang, ang);
		t = ONE_Q30 - a2 / 72;
		t = ONE_Q30 - q30_mul(a2, t) / 42;
		t = ONE_Q30 - q30_mul(a2, t) / 20;
		t = ONE_Q30 - q30_mul(a2, t) / 6;
		s = q30_mul(ang, t);
		t = ONE_Q30 - a2 / 90;
		t = ONE_Q30 - q30_mul(a2, t) / 56;
		t = ONE_Q30 - q30_mul(a2, t) / 30;
		t = ONE_Q30 - q30_mul(a2, t) / 12;
		c = ONE_Q30 - q30_mul(a2, t) / 2;
	endfunction

	// Q30 -> Q16 rounded half up
	function automatic longint unsigned q30_to_q16(longint unsigned w);
		return (w + (64'd1 << 13)) >> 14;
	endfunction

	function automatic longint ring_scale(longint unsigned r, longint unsigned m, bit neg);
		longint p;
		p = longint'((r * m) >> 16);
		return neg ? -p : p;
	endfunction

	function automatic offset_t predict_offset(logic [7:0] slot);
		offset_t o;
		longint g, xv, yv, row;
		longint unsigned n, k, turn, quad, u, radius, s, c, sm, cm, sin_m, cos_m;
		bit sin_neg, cos_neg;
		int h;
		g = longint'(cur_gap);
		xv = 0; yv = 0; h = 0;
		case (cur_pat)
			PAT_LINE: yv = -longint'(slot) * g;
			PAT_WEDGE: if (slot != 0) begin
				row = (longint'(slot) + 1) / 2;
				yv = -row * g;
				xv = (row * g) / 2;
				if (slot[0]) xv = -xv;
			end
			PAT_COLUMN: begin
				row = longint'(slot) / 2;
				yv = -row * g;
				xv = slot[0] ? g / 2 : -(g / 2);
			end
			PAT_CIRCLE: if (cur_members > 1 && slot != 0) begin
				n = cur_members - 1;
				radius = (n * cur_gap) / 6;
				if (radius < cur_gap) radius = cur_gap;
				k = (slot - 1) % n;
				turn = ((k << 16) / n) & 64'hFFFF;
				h = int'((k * 360) / n);
				quad = turn >> 14;
				u = turn & 64'h3FFF;
				if (u <= 64'h2000) octant_sincos(u, s, c);
				else octant_sincos(64'h4000 - u, c, s);
				sm = q30_to_q16(s);
				cm = q30_to_q16(c);
				case (quad)
					0: begin sin_m = sm; sin_neg = 0; cos_m = cm; cos_neg = 0; end
					1: begin sin_m = cm; sin_neg = 0; cos_m = sm; cos_neg = 1; end
					2: begin sin_m = sm; sin_neg = 1; cos_m = cm; cos_neg = 1; end
					default: begin sin_m = cm; sin_neg = 1; cos_m = sm; cos_neg = 0; end
				endcase
				xv = ring_scale(radius, sin_m, sin_neg);
				yv = ring_scale(radius, cos_m, cos_neg);
			end
			default: ;  // none and unused codes: all zero
		endcase
		o.x = xv[POS_W-1:0];
		o.y = yv[POS_W-1:0];
		o.hdg = h[HDG_W-1:0];
		return o;
	endfunction

	// ---------------- drivers ----------------

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	task automatic wait_drained();
		while (pending_offsets.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] idx, logic [15:0] val);
		cfg_we = 1'b1; cfg_addr = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_PATTERN: cur_pat = val[2:0];
			REG_MEMBERS: cur_members = val[7:0];
			REG_GAP:     cur_gap = val;
			default: ;  // unused index, ignored
		endcase
	endtask

	// quiesce, then write only what changes; ring radius needs a few cycles
	task automatic apply_config(logic [2:0] pat, logic [7:0] members, logic [15:0] gap);
		if (pat == cur_pat && members == cur_members && gap == cur_gap) return;
		wait_drained();
		if (pat != cur_pat) write_reg(REG_PATTERN, {13'd0, pat});
		if (members != cur_members) write_reg(REG_MEMBERS, {8'd0, members});
		if (gap != cur_gap) write_reg(REG_GAP, gap);
		repeat (4) @(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_slot(logic [7:0] slot);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = slot;
		do @(posedge clk); while (!s_axis_tready);
		pending_offsets.push_back(predict_offset(slot));
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	always @(negedge clk)
		m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

	// result checker
	always @(posedge clk) begin
		offset_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_offsets.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = pending_offsets.pop_front();
				if (m_axis_tdata[24:0] !== want.x)
					report_mismatch("offset_x_mm", $signed(m_axis_tdata[24:0]), $signed(want.x));
				if (m_axis_tdata[49:25] !== want.y)
					report_mismatch("offset_y_mm", $signed(m_axis_tdata[49:25]), $signed(want.y));
				if (m_axis_tdata[58:50] !== want.hdg)
					report_mismatch("heading_offset_deg", m_axis_tdata[58:50], want.hdg);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL formation_slot_offset_calculator");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	row_t directed[] = '{
		// reset config: pattern none
		'{PAT_NONE,   8'd0,   16'd1000,  8'd0,   1, 0, 0, 0},
		// line with reset gap of 1000
		'{PAT_LINE,   8'd0,   16'd1000,  8'd3,   1, 0, -3000, 0},
		'{PAT_LINE,   8'd10,  16'd65535, 8'd255, 1, 0, -16711425, 0},
		'{PAT_LINE,   8'd10,  16'd0,     8'd200, 1, 0, 0, 0},
		'{PAT_WEDGE,  8'd10,  16'd65535, 8'd0,   1, 0, 0, 0},
		'{PAT_WEDGE,  8'd10,  16'd65535, 8'd255, 1, -4194240, -8388480, 0},
		'{PAT_WEDGE,  8'd10,  16'd1001,  8'd2,   0, 0, 0, 0},
		'{PAT_COLUMN, 8'd10,  16'd1000,  8'd0,   1, -500, 0, 0},
		'{PAT_COLUMN, 8'd10,  16'd1001,  8'd255, 0, 0, 0, 0},
		'{PAT_COLUMN, 8'd10,  16'd65535, 8'd254, 0, 0, 0, 0},
		// circle leader, tiny counts
		'{PAT_CIRCLE, 8'd5,   16'd600,   8'd0,   1, 0, 0, 0},
		'{PAT_CIRCLE, 8'd0,   16'd600,   8'd3,   1, 0, 0, 0},
		'{PAT_CIRCLE, 8'd1,   16'd600,   8'd3,   1, 0, 0, 0},
		// four on the ring, radius clamps to the gap
		'{PAT_CIRCLE, 8'd5,   16'd600,   8'd1,   1, 0, 600, 0},
		'{PAT_CIRCLE, 8'd5,   16'd600,   8'd3,   1, 0, -600, 180},
		'{PAT_CIRCLE, 8'd5,   16'd600,   8'd2,   0, 0, 0, 0},
		'{PAT_CIRCLE, 8'd5,   16'd600,   8'd255, 0, 0, 0, 0},  // wraps
		'{PAT_CIRCLE, 8'd255, 16'd65535, 8'd200, 0, 0, 0, 0},
		'{PAT_CIRCLE, 8'd255, 16'd65535, 8'd255, 0, 0, 0, 0},
		'{PAT_CIRCLE, 8'd2,   16'd65535, 8'd7,   0, 0, 0, 0},
		// zero gap: zero radius, heading still spread
		'{PAT_CIRCLE, 8'd255, 16'd0,     8'd77,  1, 0, 0, 107},
		// unused pattern code acts as none
		'{3'd7,       8'd255, 16'd5000,  8'd9,   1, 0, 0, 0},
		'{3'd5,       8'd255, 16'd5000,  8'd9,   1, 0, 0, 0}
	};

	initial begin
		offset_t typed;
		logic [2:0] pat;
		logic [7:0] members, slot;
		logic [15:0] gap;
		int n_items;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed[r]) begin
			apply_config(directed[r].pat, directed[r].members, directed[r].gap);
			send_slot(directed[r].slot);
			if (directed[r].known) begin
				// swap in the typed answer for the predicted one
				typed.x = directed[r].x[POS_W-1:0];
				typed.y = directed[r].y[POS_W-1:0];
				typed.hdg = directed[r].hdg[HDG_W-1:0];
				void'(pending_offsets.pop_back());
				pending_offsets.push_back(typed);
			end
		end

		// unused register index must not disturb anything
		wait_drained();
		write_reg(2'd3, 16'hFFFF);
		send_slot(8'd5);

		// random phases, each with a fresh config
		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(9))
				0: pat = PAT_NONE;
				1: pat = PAT_LINE;
				2: pat = PAT_WEDGE;
				3: pat = PAT_COLUMN;
				4: pat = 3'($urandom_range(7, 5));
				default: pat = PAT_CIRCLE;
			endcase
			case ($urandom_range(5))
				0: members = 8'd255;
				1: members = 8'($urandom_range(2));
				2: members = 8'($urandom_range(12, 3));
				default: members = 8'($urandom_range(255));
			endcase
			case ($urandom_range(5))
				0: gap = 16'hFFFF;
				1: gap = 16'd0;
				default: gap = 16'($urandom_range(65535));
			endcase
			apply_config(pat, members, gap);
			no_idle = (ph == 5);
			n_items = 62;
			for (int j = 0; j < n_items; j++) begin
				if (ph == 3 && j == 30) begin
					// hold off until the pipe is empty
					s_axis_tvalid = 1'b0;
					while (pending_offsets.size() != 0) @(negedge clk);
				end
				if ($urandom_range(3) != 0 && members > 1)
					slot = 8'($urandom_range(members));
				else
					slot = 8'($urandom_range(255));
				send_slot(slot);
			end
			no_idle = 1'b0;
		end
		s_axis_tvalid = 1'b0;

		while (pending_offsets.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("PASS formation_slot_offset_calculator");
		else
			$display("FAIL formation_slot_offset_calculator");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/fsoc_pkg.sv
rtl/core/fsoc_front.sv
rtl/core/fsoc_queue.sv
rtl/core/fsoc_div.sv
rtl/core/fsoc_trig.sv
rtl/core/fsoc_back.sv
rtl/core/formation_slot_offset_calculator.sv
test/tb_formation_slot_offset_calculator.sv
